@@ rtl/wpm_pkg.sv @@
// shared types and constants for the wildcard pattern matcher
`default_nettype none

package wpm_pkg;

    localparam int PATTERN_MAX_DEF = 128;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CHAR   = 2'd1,
        OP_END    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic       append;
        logic       consume;
        logic       restart;
        logic [7:0] ch;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/wpm_cell.sv @@
// one pattern position: stored character, active bit and step logic
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int LEN_W = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [LEN_W-1:0] len,
    input  wire logic             closed_in,
    input  wire logic             adv_in,
    output logic                  adv_out,
    output logic                  active,
    output logic                  is_star
);

    logic [7:0] char_reg;
    logic       active_reg;
    logic       active_next;
    logic       in_pat;
    logic       char_hit;
    logic       stay;

    always_ff @(posedge clk)
    begin
        if (ctrl.append && (len == LEN_W'(IDX)))
        begin
            char_reg <= ctrl.ch;
        end
    end

    assign in_pat   = (LEN_W'(IDX) < len);
    assign is_star  = in_pat && (char_reg == CH_STAR);
    assign char_hit = (char_reg == CH_ANY) || (char_reg == ctrl.ch);
    assign stay     = closed_in && is_star;
    assign adv_out  = closed_in && in_pat && !is_star && char_hit;

    always_comb
    begin
        active_next = active_reg;
        if (ctrl.restart)
        begin
            active_next = (IDX == 0);
        end
        else if (ctrl.consume)
        begin
            active_next = stay || adv_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= (IDX == 0);
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    assign active = active_reg;

endmodule

`default_nettype wire

@@ rtl/wpm_closure.sv @@
// star closure of the active set as one carry chain
`default_nettype none

module wpm_closure
    import wpm_pkg::*;
#(
    parameter int N = PATTERN_MAX_DEF
)
(
    input  wire logic [N:0]   active,
    input  wire logic [N-1:0] star,
    output logic      [N:0]   closed
);

    logic [N:0] star_ext;
    logic [N:0] seed;
    logic [N:0] sum;
    logic [N:0] carry;

    // a carry entering a position means an active star run reaches it
    assign star_ext = {1'b0, star};
    assign seed     = active & star_ext;
    assign sum      = star_ext + seed;
    assign carry    = sum ^ star_ext ^ seed;
    assign closed   = active | carry;

endmodule

`default_nettype wire

@@ rtl/wildcard_pattern_matcher_top.sv @@
// top level of the wildcard pattern matcher
`default_nettype none

// Glob matcher for '?' (any one character) and '*' (any run, also empty).
// Pattern characters are appended one item at a time (dropped past
// PATTERN_MAX, which sets the sticky overflow flag until a clear); string
// characters then stream in, and an end-of-string item returns matched and
// pattern_overflow and restarts tracking. Appending or clearing also
// restarts tracking. A row of PATTERN_MAX cells, one per pattern position,
// updates all active bits at once, with star runs closed by a single
// PATTERN_MAX+1 bit carry chain, so items are taken back to back while
// result_stall is low; a held result stalls the input.

module wildcard_pattern_matcher_top
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] char_value,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            matched,
    output logic            pattern_overflow
);

    localparam int N     = PATTERN_MAX;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             last_reg;
    logic             last_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             matched_reg;
    logic             matched_next;
    logic             ovf_out_reg;
    logic             ovf_out_next;

    logic             accept;
    logic             full;
    op_t              op;
    cell_ctrl_t       ctrl;
    logic [N:0]       active;
    logic [N:0]       closed;
    logic [N:0]       adv;
    logic [N-1:0]     star;
    logic [N:0]       hit_vec;
    logic             hit;

    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign op         = op_t'(operation);
    assign full       = (len_reg == LEN_W'(PATTERN_MAX));

    always_comb
    begin
        ctrl.append  = 1'b0;
        ctrl.consume = 1'b0;
        ctrl.restart = 1'b0;
        ctrl.ch      = char_value;
        if (accept)
        begin
            case (op)
                OP_APPEND:
                begin
                    ctrl.append  = !full;
                    ctrl.restart = 1'b1;
                end
                OP_CHAR:
                begin
                    ctrl.consume = 1'b1;
                end
                OP_END:
                begin
                    ctrl.restart = 1'b1;
                end
                OP_CLEAR:
                begin
                    ctrl.restart = 1'b1;
                end
                default:
                begin
                    ctrl.restart = 1'b0;
                end
            endcase
        end
    end

    assign adv[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        wpm_cell #(
            .IDX   (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .len       (len_reg),
            .closed_in (closed[i]),
            .adv_in    (adv[i]),
            .adv_out   (adv[i+1]),
            .active    (active[i]),
            .is_star   (star[i])
        );
    end

    assign active[N] = last_reg;

    wpm_closure #(
        .N (N)
    ) u_closure (
        .active (active),
        .star   (star),
        .closed (closed)
    );

    for (genvar i = 0; i <= N; i++)
    begin : g_hit
        assign hit_vec[i] = closed[i] && (len_reg == LEN_W'(i));
    end

    assign hit = |hit_vec;

    always_comb
    begin
        len_next          = len_reg;
        ovf_next          = ovf_reg;
        last_next         = last_reg;
        matched_next      = matched_reg;
        ovf_out_next      = ovf_out_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (ctrl.restart)
        begin
            last_next = 1'b0;
        end
        else if (ctrl.consume)
        begin
            last_next = adv[N];
        end
        if (accept)
        begin
            case (op)
                OP_APPEND:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
                OP_END:
                begin
                    result_valid_next = 1'b1;
                    matched_next      = hit;
                    ovf_out_next      = ovf_reg;
                end
                OP_CLEAR:
                begin
                    len_next = '0;
                    ovf_next = 1'b0;
                end
                default:
                begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            ovf_reg          <= 1'b0;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            ovf_reg          <= ovf_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign result_valid     = result_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = ovf_out_reg;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PATTERN_MAX))
        else $error("pattern length beyond store size");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_CLEAR)) |=> (len_reg == '0) && !ovf_reg)
        else $error("clear did not empty the pattern");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == OP_END)) |=> (active == (N+1)'(1)) && result_valid_reg)
        else $error("end of string did not restart tracking");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> (len_reg == LEN_W'(PATTERN_MAX)))
        else $error("overflow set while pattern not full");
`endif

endmodule

`default_nettype wire
